// ===== hw/rtl/fsff_pkg.sv =====
// shared constants for the fixed-slot frame fifo
package fsff_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int SLOT_BYTES_DEF = 64;

    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 7;
    localparam int STATUS_W    = 3;
    localparam int FRAMES_W    = 5;
    localparam int BYTES_W     = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DATA    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMMIT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES_IN_USE = 1'd1;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;
    localparam logic [BYTES_W-1:0]  BYTES_RESET  = 7'd64;

endpackage

// ===== hw/rtl/fixed_slot_frame_fifo_top.sv =====
// fixed-slot frame fifo: frame ring, slot memories and removal sequencer
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in      | in        | in_valid/in_stall   | action, data_byte, frame_end
//  out     | out       | out_valid/out_stall | out_byte, out_last, frame_length, status
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
//  append, clear, empty remove: handled in the idle state, result registered at the output
//  remove: length read, then one byte per cycle from the data memory port while not stalled
//  a removed frame keeps the input stalled from acceptance until its last byte is registered
//  out_stall holds the output register and pauses the byte sequencer
//  rst_n empties the ring; the slot memories are not cleared
module fixed_slot_frame_fifo_top #(
    parameter int MAX_FRAMES = fsff_pkg::MAX_FRAMES_DEF,
    parameter int SLOT_BYTES = fsff_pkg::SLOT_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fsff_pkg::ACTION_W-1:0]       action,
    input  logic [fsff_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fsff_pkg::BYTE_W-1:0]         out_byte,
    output logic                                out_last,
    output logic [fsff_pkg::FRAME_LEN_W-1:0]    frame_length,
    output logic [fsff_pkg::STATUS_W-1:0]       status,
    input  logic                                cfg_we,
    input  logic [fsff_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsff_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int FCW   = $clog2(MAX_FRAMES + 1);
    localparam int LW    = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH = MAX_FRAMES * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LOW   = fsff_pkg::FRAME_LEN_W;
    localparam int BYW   = fsff_pkg::BYTE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [FW-1:0]  write_slot_reg, write_slot_next;
    logic [FW-1:0]  read_slot_reg, read_slot_next;
    logic [FCW-1:0] frame_count_reg, frame_count_next;
    logic [LW-1:0]  fill_reg, fill_next;
    logic           ovf_reg, ovf_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [AW-1:0]  rd_addr_reg, rd_addr_next;

    logic [fsff_pkg::FRAMES_W-1:0] frames_cfg_reg;
    logic [fsff_pkg::BYTES_W-1:0]  bytes_cfg_reg;

    logic           out_valid_reg, out_valid_next;
    logic [BYW-1:0] out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;
    logic [LOW-1:0] frame_length_reg, frame_length_next;
    logic [fsff_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [BYW-1:0] data_mem [DEPTH];
    logic [LW-1:0]  len_mem [MAX_FRAMES];
    logic [BYW-1:0] rd_data_reg;
    logic [LW-1:0]  rd_len_reg;

    logic           dmem_we, dmem_re, lmem_we, lmem_re;
    logic [AW-1:0]  dmem_waddr;

    logic [FCW-1:0] frames_eff;
    logic [LW-1:0]  limit_eff;
    logic           full;
    logic           out_free;
    logic           in_acc;
    logic [FCW-1:0] wslot_inc, rslot_inc;
    logic [LW-1:0]  fill_after;
    logic           ovf_after;
    logic           is_last;

    always_comb
    begin
        if (frames_cfg_reg == '0)
            frames_eff = FCW'(1);
        else if (int'(frames_cfg_reg) > MAX_FRAMES)
            frames_eff = FCW'(MAX_FRAMES);
        else
            frames_eff = FCW'(frames_cfg_reg);
        if (bytes_cfg_reg == '0)
            limit_eff = LW'(1);
        else if (int'(bytes_cfg_reg) > SLOT_BYTES)
            limit_eff = LW'(SLOT_BYTES);
        else
            limit_eff = LW'(bytes_cfg_reg);
    end

    assign full      = frame_count_reg >= frames_eff;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign wslot_inc = FCW'(write_slot_reg) + FCW'(1);
    assign rslot_inc = FCW'(read_slot_reg) + FCW'(1);
    assign is_last   = (idx_reg + LW'(1)) == len_reg;
    assign dmem_waddr = AW'(write_slot_reg) * AW'(SLOT_BYTES) + AW'(fill_reg);

    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        frame_count_next  = frame_count_reg;
        fill_next         = fill_reg;
        ovf_next          = ovf_reg;
        idx_next          = idx_reg;
        len_next          = len_reg;
        rd_addr_next      = rd_addr_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        frame_length_next = frame_length_reg;
        status_next       = status_reg;
        dmem_we           = 1'b0;
        dmem_re           = 1'b0;
        lmem_we           = 1'b0;
        lmem_re           = 1'b0;
        fill_after        = fill_reg;
        ovf_after         = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        fsff_pkg::ACT_APPEND:
                        begin
                            if (full)
                                ovf_after = 1'b1;
                            else if (fill_reg < limit_eff)
                            begin
                                dmem_we    = 1'b1;
                                fill_after = fill_reg + LW'(1);
                            end
                            else
                                ovf_after = 1'b1;
                            fill_next = fill_after;
                            ovf_next  = ovf_after;
                            if (frame_end)
                            begin
                                out_valid_next    = 1'b1;
                                out_byte_next     = '0;
                                out_last_next     = 1'b1;
                                frame_length_next = LOW'(fill_after);
                                if (full)
                                    status_next = fsff_pkg::ST_FULL;
                                else
                                begin
                                    lmem_we          = 1'b1;
                                    write_slot_next  = (wslot_inc >= frames_eff) ? '0
                                                                                 : FW'(wslot_inc);
                                    frame_count_next = frame_count_reg + FCW'(1);
                                    status_next      = ovf_after ? fsff_pkg::ST_TRUNC
                                                                 : fsff_pkg::ST_COMMIT;
                                end
                                fill_next = '0;
                                ovf_next  = 1'b0;
                            end
                        end
                        fsff_pkg::ACT_REMOVE:
                        begin
                            if (frame_count_reg == '0)
                            begin
                                out_valid_next    = 1'b1;
                                out_byte_next     = '0;
                                out_last_next     = 1'b1;
                                frame_length_next = '0;
                                status_next       = fsff_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lmem_re          = 1'b1;
                                rd_addr_next     = AW'(read_slot_reg) * AW'(SLOT_BYTES);
                                read_slot_next   = (rslot_inc >= frames_eff) ? '0
                                                                             : FW'(rslot_inc);
                                frame_count_next = frame_count_reg - FCW'(1);
                                state_next       = S_LEN;
                            end
                        end
                        fsff_pkg::ACT_CLEAR:
                        begin
                            read_slot_next    = write_slot_reg;
                            frame_count_next  = '0;
                            fill_next         = '0;
                            ovf_next          = 1'b0;
                            out_valid_next    = 1'b1;
                            out_byte_next     = '0;
                            out_last_next     = 1'b1;
                            frame_length_next = '0;
                            status_next       = fsff_pkg::ST_CLEARED;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                // zero stored length reads out as one byte
                len_next     = (rd_len_reg == '0) ? LW'(1) : rd_len_reg;
                idx_next     = '0;
                dmem_re      = 1'b1;
                rd_addr_next = rd_addr_reg + AW'(1);
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_byte_next     = rd_data_reg;
                    out_last_next     = is_last;
                    frame_length_next = LOW'(len_reg);
                    status_next       = fsff_pkg::ST_DATA;
                    if (is_last)
                        state_next = S_IDLE;
                    else
                    begin
                        dmem_re      = 1'b1;
                        rd_addr_next = rd_addr_reg + AW'(1);
                        idx_next     = idx_reg + LW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes reset the ring
        if (cfg_we)
        begin
            write_slot_next  = '0;
            read_slot_next   = '0;
            frame_count_next = '0;
            fill_next        = '0;
            ovf_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            frame_count_reg <= '0;
            fill_reg        <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            frames_cfg_reg  <= fsff_pkg::FRAMES_RESET;
            bytes_cfg_reg   <= fsff_pkg::BYTES_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            frame_count_reg <= frame_count_next;
            fill_reg        <= fill_next;
            ovf_reg         <= ovf_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fsff_pkg::CFG_FRAMES_IN_USE:
                        frames_cfg_reg <= cfg_data[fsff_pkg::FRAMES_W-1:0];
                    fsff_pkg::CFG_SLOT_BYTES_IN_USE:
                        bytes_cfg_reg <= cfg_data[fsff_pkg::BYTES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        len_reg          <= len_next;
        rd_addr_reg      <= rd_addr_next;
        out_byte_reg     <= out_byte_next;
        out_last_reg     <= out_last_next;
        frame_length_reg <= frame_length_next;
        status_reg       <= status_next;
    end

    // slot data memory
    always_ff @(posedge clk)
    begin
        if (dmem_we)
            data_mem[dmem_waddr] <= data_byte;
        if (dmem_re)
            rd_data_reg <= data_mem[rd_addr_reg];
    end

    // slot length memory
    always_ff @(posedge clk)
    begin
        if (lmem_we)
            len_mem[write_slot_reg] <= fill_after;
        if (lmem_re)
            rd_len_reg <= len_mem[read_slot_reg];
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign frame_length = frame_length_reg;
    assign status       = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= frames_eff)
        else $error("frame count beyond ring size");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= limit_eff)
        else $error("fill position beyond slot limit");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (idx_reg < len_reg))
        else $error("byte index past frame length");

    a_remove_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == fsff_pkg::ACT_REMOVE && frame_count_reg != '0 && !cfg_we)
        |=> (state_reg == S_LEN))
        else $error("remove did not start length read");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the fixed-slot frame fifo with a built-in frame ring predictor
module tb;

    localparam logic [fsff_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 50;

    typedef struct packed {
        logic [fsff_pkg::BYTE_W-1:0]      data;
        logic                             last;
        logic [fsff_pkg::FRAME_LEN_W-1:0] len;
        logic [fsff_pkg::STATUS_W-1:0]    stat;
    } out_word_t;

    typedef struct packed {
        logic                            is_cfg;
        logic [fsff_pkg::CFG_IDX_W-1:0]  idx;
        logic [fsff_pkg::ACTION_W-1:0]   act;
        logic [fsff_pkg::BYTE_W-1:0]     dbyte;
        logic                            fend;
        logic                            typed;
        out_word_t                       want;
    } plan_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [fsff_pkg::ACTION_W-1:0]    action;
    logic [fsff_pkg::BYTE_W-1:0]      data_byte;
    logic                             frame_end;
    logic                             out_valid;
    logic                             out_stall;
    logic [fsff_pkg::BYTE_W-1:0]      out_byte;
    logic                             out_last;
    logic [fsff_pkg::FRAME_LEN_W-1:0] frame_length;
    logic [fsff_pkg::STATUS_W-1:0]    status;
    logic                             cfg_we;
    logic [fsff_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [fsff_pkg::CFG_DATA_W-1:0]  cfg_data;

    fixed_slot_frame_fifo_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .frame_length (frame_length),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [fsff_pkg::FRAMES_W-1:0] ring_frames_cfg = fsff_pkg::FRAMES_RESET;
    logic [fsff_pkg::BYTES_W-1:0]  ring_bytes_cfg  = fsff_pkg::BYTES_RESET;
    int                            wr_slot = 0;
    int                            rd_slot = 0;
    int                            held    = 0;
    int                            fill    = 0;
    bit                            dropped = 0;
    int                            slot_len [fsff_pkg::MAX_FRAMES_DEF];
    logic [fsff_pkg::BYTE_W-1:0]
        slot_mem [fsff_pkg::MAX_FRAMES_DEF][fsff_pkg::SLOT_BYTES_DEF];

    out_word_t expected_words [$];
    out_word_t step_words [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        hold_req = 0;
    bit        calm = 0;

    plan_row_t plan [22] = '{
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_EMPTY}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, ACT_UNUSED, 8'hFF, 1'b1, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'hFF, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd2, fsff_pkg::ST_COMMIT}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'hA5, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd1, fsff_pkg::ST_COMMIT}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_CLEAR,  8'h00, 1'b0, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_CLEARED}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'hFF, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_EMPTY}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h5A, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_CLEAR,  8'hFF, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_CLEARED}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h3C, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd1, fsff_pkg::ST_COMMIT}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, fsff_pkg::CFG_FRAMES_IN_USE,     fsff_pkg::ACT_APPEND, 8'd1, 1'b0, 1'b0, '0},
        '{1'b1, fsff_pkg::CFG_SLOT_BYTES_IN_USE, fsff_pkg::ACT_APPEND, 8'd1, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h11, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h22, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd1, fsff_pkg::ST_TRUNC}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h33, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_FULL}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h44, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_APPEND, 8'h55, 1'b1, 1'b1,
          '{8'h00, 1'b1, 7'd1, fsff_pkg::ST_TRUNC}},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, fsff_pkg::CFG_FRAMES_IN_USE, fsff_pkg::ACT_REMOVE, 8'h00, 1'b0, 1'b1,
          '{8'h00, 1'b1, 7'd0, fsff_pkg::ST_EMPTY}}
    };

    int phase_frames [PHASES] = '{16, 2, 0, 31, 5, 16};
    int phase_bytes  [PHASES] = '{64, 3, 0, 127, 9, 64};

    function automatic out_word_t make_word(input logic [fsff_pkg::BYTE_W-1:0] data,
                                            input logic last, input int len,
                                            input logic [fsff_pkg::STATUS_W-1:0] stat);
        out_word_t w;
        w.data = data;
        w.last = last;
        w.len  = len[fsff_pkg::FRAME_LEN_W-1:0];
        w.stat = stat;
        return w;
    endfunction

    function automatic logic [fsff_pkg::BYTE_W-1:0] rand_byte();
        int unsigned v;
        v = $urandom_range(0, 255);
        return v[fsff_pkg::BYTE_W-1:0];
    endfunction

    function automatic logic rand_bit();
        int unsigned v;
        v = $urandom_range(0, 1);
        return v[0];
    endfunction

    function automatic void ring_step(input logic [fsff_pkg::ACTION_W-1:0] act,
                                      input logic [fsff_pkg::BYTE_W-1:0] b, input logic fe);
        int frames;
        int limit;
        int len;
        step_words.delete();
        frames = (ring_frames_cfg < 1) ? 1 :
                 (ring_frames_cfg > fsff_pkg::MAX_FRAMES_DEF) ? fsff_pkg::MAX_FRAMES_DEF
                                                              : int'(ring_frames_cfg);
        limit  = (ring_bytes_cfg < 1) ? 1 :
                 (ring_bytes_cfg > fsff_pkg::SLOT_BYTES_DEF) ? fsff_pkg::SLOT_BYTES_DEF
                                                             : int'(ring_bytes_cfg);
        if (wr_slot >= frames)
            wr_slot = 0;
        if (rd_slot >= frames)
            rd_slot = 0;
        case (act)
            fsff_pkg::ACT_APPEND:
            begin
                if (held >= frames)
                    dropped = 1;
                else if (fill < limit)
                begin
                    slot_mem[wr_slot][fill] = b;
                    fill++;
                end
                else
                    dropped = 1;
                if (fe)
                begin
                    if (held >= frames)
                        step_words.push_back(make_word(8'h00, 1'b1, fill, fsff_pkg::ST_FULL));
                    else
                    begin
                        slot_len[wr_slot] = fill;
                        wr_slot = (wr_slot + 1 >= frames) ? 0 : wr_slot + 1;
                        held++;
                        step_words.push_back(make_word(8'h00, 1'b1, fill,
                                                       dropped ? fsff_pkg::ST_TRUNC
                                                               : fsff_pkg::ST_COMMIT));
                    end
                    fill = 0;
                    dropped = 0;
                end
            end
            fsff_pkg::ACT_REMOVE:
            begin
                if (held == 0)
                    step_words.push_back(make_word(8'h00, 1'b1, 0, fsff_pkg::ST_EMPTY));
                else
                begin
                    len = slot_len[rd_slot];
                    for (int i = 0; i < len; i++)
                        step_words.push_back(make_word(slot_mem[rd_slot][i], i + 1 == len,
                                                       len, fsff_pkg::ST_DATA));
                    rd_slot = (rd_slot + 1 >= frames) ? 0 : rd_slot + 1;
                    held--;
                end
            end
            fsff_pkg::ACT_CLEAR:
            begin
                rd_slot = wr_slot;
                held = 0;
                fill = 0;
                dropped = 0;
                step_words.push_back(make_word(8'h00, 1'b1, 0, fsff_pkg::ST_CLEARED));
            end
            default: ;
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic put_word(input logic [fsff_pkg::ACTION_W-1:0] act,
                            input logic [fsff_pkg::BYTE_W-1:0] b,
                            input logic fe, input logic typed, input out_word_t want);
        if (!calm && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
        in_valid  = 1'b1;
        action    = act;
        data_byte = b;
        frame_end = fe;
        do
            @(posedge clk);
        while (in_stall);
        ring_step(act, b, fe);
        if (typed)
            expected_words.push_back(want);
        else
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [fsff_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fsff_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == fsff_pkg::CFG_FRAMES_IN_USE)
            ring_frames_cfg = val[fsff_pkg::FRAMES_W-1:0];
        else
            ring_bytes_cfg = val[fsff_pkg::BYTES_W-1:0];
        wr_slot = 0;
        rd_slot = 0;
        held    = 0;
        fill    = 0;
        dropped = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: random stall bursts and one long hold-off
    initial
    begin : rx_side
        int n;
        bit hold_taken;
        hold_taken = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                n = HOLD_CYCLES;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
                n = $urandom_range(1, 16);
            else
                n = 0;
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        out_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %0h status %0d", out_byte, status);
                errors++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (out_byte !== w.data)
                begin
                    $error("out_byte: expected %0h, got %0h", w.data, out_byte);
                    errors++;
                end
                if (out_last !== w.last)
                begin
                    $error("out_last: expected %0d, got %0d", w.last, out_last);
                    errors++;
                end
                if (frame_length !== w.len)
                begin
                    $error("frame_length: expected %0d, got %0d", w.len, frame_length);
                    errors++;
                end
                if (status !== w.stat)
                begin
                    $error("status: expected %0d, got %0d", w.stat, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[fixed_slot_frame_fifo_top] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int done;
        int r;
        int flen;
        int lim;
        bit paused;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = fsff_pkg::ACT_APPEND;
        data_byte = '0;
        frame_end = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = fsff_pkg::CFG_FRAMES_IN_USE;
        cfg_data  = '0;
        paused    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].dbyte[fsff_pkg::CFG_DATA_W-1:0]);
            else
                put_word(plan[i].act, plan[i].dbyte, plan[i].fend, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(fsff_pkg::CFG_FRAMES_IN_USE, phase_frames[ph][fsff_pkg::CFG_DATA_W-1:0]);
            write_reg(fsff_pkg::CFG_SLOT_BYTES_IN_USE,
                      phase_bytes[ph][fsff_pkg::CFG_DATA_W-1:0]);
            lim  = (phase_bytes[ph] < 1) ? 1 :
                   (phase_bytes[ph] > fsff_pkg::SLOT_BYTES_DEF) ? fsff_pkg::SLOT_BYTES_DEF
                                                                : phase_bytes[ph];
            calm = (ph == PHASES - 1);
            // in the first phase, request the receiver's long hold-off while words are offered
            if (ph == 0)
                hold_req = 1'b1;
            done = 0;
            while (done < PHASE_WORDS)
            begin
                if (ph == 2 && done >= PHASE_WORDS / 2 && !paused)
                begin
                    wait_drained();
                    paused = 1;
                end
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    flen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70)
                                                        : $urandom_range(1, lim + 2);
                    for (int k = 0; k < flen; k++)
                        put_word(fsff_pkg::ACT_APPEND, rand_byte(), k == flen - 1, 1'b0, '0);
                    done += flen;
                end
                else if (r < 85)
                begin
                    put_word(fsff_pkg::ACT_REMOVE, rand_byte(), rand_bit(), 1'b0, '0);
                    done++;
                end
                else if (r < 90)
                begin
                    put_word(fsff_pkg::ACT_CLEAR, rand_byte(), rand_bit(), 1'b0, '0);
                    done++;
                end
                else if (r < 95)
                    put_word(ACT_UNUSED, rand_byte(), rand_bit(), 1'b0, '0);
                else
                begin
                    // unfinished frame, merged into the next frame unless a clear or register write drops it
                    flen = $urandom_range(1, 4);
                    for (int k = 0; k < flen; k++)
                        put_word(fsff_pkg::ACT_APPEND, rand_byte(), 1'b0, 1'b0, '0);
                    done += flen;
                end
            end
        end

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[fixed_slot_frame_fifo_top] OK");
        else
            $display("[fixed_slot_frame_fifo_top] ERROR");
        $finish;
    end

endmodule
